// ===== hdl/otcw_pkg.sv =====
// Shared types and constants of the OLED text cell writer.
package otcw_pkg;

   typedef enum logic [1:0] {
      MODE_LOAD        = 2'd0,
      MODE_DRAW_CELL   = 2'd1,
      MODE_DRAW_CURSOR = 2'd2,
      MODE_CLEAR       = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // last member sits in the lowest bits, matching the req_tdata layout
   typedef struct packed {
      logic [7:0]  font_byte;
      logic [10:0] font_address;
      logic [7:0]  character_code;
      logic [3:0]  cell_column;
      logic [1:0]  cell_row;
      mode_type    mode;
   } req_item_type;

   // one output word in flight between sequencer and output register
   typedef struct packed {
      logic       valid;
      logic       is_data;
      logic       blank;
      logic       last;
      logic [7:0] cmd_byte;
   } beat_type;

   localparam int          STEP_W       = 5;
   localparam int          CELL_RESULTS = 22;
   localparam int          HALF_RESULTS = 11;
   localparam int          POS_CMDS     = 3;
   localparam int          FIRST_CODE   = 32;
   localparam int          GLYPH_BYTES  = 16;
   localparam int          REQ_BITS     = 35;
   localparam logic [7:0]  PAGE_CMD     = 8'hB0;
   localparam logic [7:0]  COL_HIGH_CMD = 8'h10;

endpackage

// ===== hdl/oled_text_cell_writer_top.sv =====
// Top level of the OLED text cell writer: font memory, sequencer and output register.
//
// Turns text cells into the byte stream of a page-addressed OLED controller.
// req_ channel: one word per request. Mode 0 writes one byte into the font
//   memory and gives no output; modes 1 and 2 draw a character at the given
//   cell or at the cursor; mode 3 blanks the given cell.
// rsp_ channel: each drawn or cleared cell gives 22 words: a page/column
//   command triple, eight glyph bytes, a second triple and eight more bytes.
//   rsp_tuser is high on glyph bytes (DC high), rsp_tlast on the 22nd word.
// Throughput: a font load gives no output; a cell keeps req_tready low while the
//   sequencer issues its 22 words, one per cycle unless rsp_tready holds the output,
//   from a single font memory read port, so the next cell is taken only after it ends.
// A cell's words pass the sequencer step register, beat_ff and the output register.
// Load the whole font before drawing; unloaded glyph bytes read as garbage.
// Reset clears the cursor to row 0, column 0 and empties the pipeline; the
//   font memory keeps its contents.
// When the output register holds a word that rsp_tready does not take, the whole word
//   pipeline holds, and req_tready stays low until the sequencer can finish the cell.
module oled_text_cell_writer_top #(
   parameter int GLYPH_COUNT  = 96,
   parameter int TEXT_COLUMNS = 16,
   parameter int TEXT_ROWS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[1:0], cell_row[3:2], cell_column[7:4], character_code[15:8],
   // font_address[26:16], font_byte[34:27], zeros[39:35]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   // is_data[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   localparam int FONT_DEPTH = GLYPH_COUNT * otcw_pkg::GLYPH_BYTES;
   localparam int GLYPH_W    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int ADDR_W     = GLYPH_W + 4;

   otcw_pkg::req_item_type req;
   otcw_pkg::beat_type     beat;
   otcw_pkg::beat_type     beat_ff;

   logic              advance;
   logic              font_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_data_ff;
   logic       rsp_last_ff;

   assign req = otcw_pkg::req_item_type'(req_tdata[otcw_pkg::REQ_BITS-1:0]);

   // word pipeline moves only when the output register is free or drained
   assign advance = !rsp_tvalid_ff || rsp_tready;

   assign font_wr = req_tvalid && req_tready && (req.mode == otcw_pkg::MODE_LOAD)
                    && ({1'b0, req.font_address} < 12'(FONT_DEPTH));

   otcw_sequencer #(
      .GLYPH_COUNT  (GLYPH_COUNT),
      .TEXT_COLUMNS (TEXT_COLUMNS),
      .TEXT_ROWS    (TEXT_ROWS),
      .GLYPH_W      (GLYPH_W)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req        (req),
      .advance    (advance),
      .req_tready (req_tready),
      .beat       (beat),
      .rd_addr    (rd_addr)
   );

   otcw_font_mem #(
      .DEPTH  (FONT_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_font_mem (
      .clock   (clock),
      .wr_en   (font_wr),
      .wr_addr (ADDR_W'(req.font_address)),
      .wr_data (req.font_byte),
      .rd_en   (advance && beat.valid && beat.is_data && !beat.blank),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stage alongside the memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else if (advance) begin
         beat_ff <= beat;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (advance) begin
         rsp_tvalid_in = beat_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= beat_ff.is_data;
         rsp_last_ff <= beat_ff.last;
         if (!beat_ff.is_data) begin
            rsp_byte_ff <= beat_ff.cmd_byte;
         end else if (beat_ff.blank) begin
            rsp_byte_ff <= '0;
         end else begin
            rsp_byte_ff <= rd_data;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/otcw_font_mem.sv =====
// Font memory: one write port, one registered read port.
module otcw_font_mem #(
   parameter int DEPTH  = 1536,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/otcw_sequencer.sv =====
// Cell sequencer: takes draw requests, keeps the cursor, steps through the 22 words.
module otcw_sequencer #(
   parameter int GLYPH_COUNT  = 96,
   parameter int TEXT_COLUMNS = 16,
   parameter int TEXT_ROWS    = 4,
   parameter int GLYPH_W      = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  otcw_pkg::req_item_type   req,
   input  logic                     advance,
   output logic                     req_tready,
   output otcw_pkg::beat_type       beat,
   output logic [GLYPH_W+3:0]       rd_addr
);

   otcw_pkg::state_type state_ff, state_in;
   logic [otcw_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0]         cursor_row_ff, cursor_row_in;
   logic [3:0]         cursor_column_ff, cursor_column_in;
   logic [1:0]         row_ff;
   logic [3:0]         column_ff;
   logic [GLYPH_W-1:0] glyph_ff;
   logic               blank_ff;

   logic [1:0] row_fold [4];
   logic [3:0] col_fold [16];

   logic       accept, draw, run, last_step;
   logic [1:0] row_eff;
   logic [3:0] col_eff;
   logic [4:0] col_plus;
   logic [2:0] row_plus;
   logic [7:0] code_off;
   logic       has_glyph;
   logic       upper;
   logic [3:0] sub_step;
   logic [2:0] page;
   logic [2:0] byte_idx;

   // out-of-grid cells fold back by a constant table
   genvar v;
   generate
      for (v = 0; v < 4; v++) begin : g_row_fold
         assign row_fold[v] = 2'(v % TEXT_ROWS);
      end
      for (v = 0; v < 16; v++) begin : g_col_fold
         assign col_fold[v] = 4'(v % TEXT_COLUMNS);
      end
   endgenerate

   assign accept = req_tvalid && req_tready;
   assign draw   = accept && (req.mode != otcw_pkg::MODE_LOAD);

   always_comb begin
      if (req.mode == otcw_pkg::MODE_DRAW_CURSOR) begin
         row_eff = cursor_row_ff;
         col_eff = cursor_column_ff;
      end else begin
         row_eff = row_fold[req.cell_row];
         col_eff = col_fold[req.cell_column];
      end
   end

   assign code_off  = req.character_code - 8'(otcw_pkg::FIRST_CODE);
   assign has_glyph = (req.character_code >= 8'(otcw_pkg::FIRST_CODE))
                      && ({1'b0, code_off} < 9'(GLYPH_COUNT));

   assign col_plus = {1'b0, col_eff} + 5'd1;
   assign row_plus = {1'b0, row_eff} + 3'd1;

   // cursor moves past the drawn cell; clear leaves it alone
   always_comb begin
      cursor_row_in    = cursor_row_ff;
      cursor_column_in = cursor_column_ff;
      if (draw && (req.mode != otcw_pkg::MODE_CLEAR)) begin
         if (col_plus >= 5'(TEXT_COLUMNS)) begin
            cursor_column_in = '0;
            cursor_row_in    = (row_plus >= 3'(TEXT_ROWS)) ? 2'd0 : row_plus[1:0];
         end else begin
            cursor_column_in = col_plus[3:0];
            cursor_row_in    = row_eff;
         end
      end
   end

   assign last_step = (step_ff == otcw_pkg::STEP_W'(otcw_pkg::CELL_RESULTS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         otcw_pkg::ST_IDLE: begin
            if (draw) begin
               state_in = otcw_pkg::ST_RUN;
            end
         end
         otcw_pkg::ST_RUN: begin
            if (advance && last_step) begin
               state_in = otcw_pkg::ST_IDLE;
            end
         end
         default: state_in = otcw_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      unique case (state_ff)
         otcw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            run        = 1'b0;
         end
         otcw_pkg::ST_RUN: begin
            req_tready = 1'b0;
            run        = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            run        = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (draw) begin
         step_in = '0;
      end else if (run && advance) begin
         step_in = step_ff + otcw_pkg::STEP_W'(1);
      end
   end

   // word decode: three position commands then eight glyph bytes, twice
   assign upper    = (step_ff < otcw_pkg::STEP_W'(otcw_pkg::HALF_RESULTS));
   assign sub_step = upper ? step_ff[3:0]
                           : 4'(step_ff - otcw_pkg::STEP_W'(otcw_pkg::HALF_RESULTS));
   assign page     = {row_ff, ~upper};
   assign byte_idx = 3'(sub_step - 4'(otcw_pkg::POS_CMDS));

   always_comb begin
      beat.valid   = run;
      beat.is_data = (sub_step >= 4'(otcw_pkg::POS_CMDS));
      beat.blank   = blank_ff;
      beat.last    = last_step;
      priority case (sub_step)
         4'd0:    beat.cmd_byte = otcw_pkg::PAGE_CMD | {5'd0, page};
         4'd1:    beat.cmd_byte = {4'd0, column_ff[0], 3'd0};
         4'd2:    beat.cmd_byte = otcw_pkg::COL_HIGH_CMD | {5'd0, column_ff[3:1]};
         default: beat.cmd_byte = '0;
      endcase
   end

   assign rd_addr = {glyph_ff, ~upper, byte_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= otcw_pkg::ST_IDLE;
         step_ff          <= '0;
         cursor_row_ff    <= '0;
         cursor_column_ff <= '0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         cursor_row_ff    <= cursor_row_in;
         cursor_column_ff <= cursor_column_in;
      end
   end

   always_ff @(posedge clock) begin
      if (draw) begin
         row_ff    <= row_eff;
         column_ff <= col_eff;
         glyph_ff  <= code_off[GLYPH_W-1:0];
         blank_ff  <= (req.mode == otcw_pkg::MODE_CLEAR) || !has_glyph;
      end
   end

endmodule
